>>> rtl/core/bop_pkg.sv
`timescale 1ns / 1ps
package bop_pkg;
  localparam int OffsetCount = 63;
  localparam int RecentEntries = 256;
  localparam int AddrW = 48;
  localparam int OffW = 6;
  localparam int ScoreW = 8;
  localparam int SlotW = $clog2(RecentEntries);
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgWatchReads = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgWatchWrites = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRoundLimit = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgScoreLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgStartOffset = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgScanMode = 3'd5;

  localparam logic [1:0] KindRead = 2'd0;
  localparam logic [1:0] KindWrite = 2'd1;
  localparam logic [1:0] KindOther = 2'd2;
  localparam logic [1:0] KindReserved = 2'd3;

  typedef struct packed {
    logic [AddrW-1:0] line_addr;
    logic [AddrW-1:0] request_cycle;
    logic [AddrW-1:0] completion_cycle;
    logic [1:0] req_kind;
    logic speculative;
    logic instruction_fetch;
  } req_t;

  typedef struct packed {
    logic prefetch_valid;
    logic [AddrW-1:0] prefetch_addr;
    logic phase_ended;
    logic [OffW-1:0] new_offset;
  } rsp_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_RR_CHK, S_SC_RD, S_SC_CHK, S_SC_DEC,
    S_BEST, S_BEST_WAIT, S_BEST_DONE, S_CLR, S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;      // latch request, decide watched
    logic rd_issue;     // issue table read for current probe
    logic rr_eval;      // round-robin decision
    logic sc_bump;      // scan: apply hit for probe
    logic probe_next;   // advance probe counter
    logic probe_clr;
    logic sc_decide;    // phase decision after best search
    logic best_clr;
    logic best_step;
    logic clr_step;
    logic finish;       // write table, build response
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic watched;
    logic scan;
    logic probe_last;
    logic rr_hit_end;   // rr: ends by score
    logic rr_round_end; // rr: ends by rounds
    logic end_phase;    // latched phase-end flag
  } sts_t;
endpackage

>>> rtl/core/best_offset_prefetcher_top.sv
`timescale 1ns / 1ps
// Best-offset prefetcher: one demand miss in, one prefetch response out.
// Request channel: req_valid/req_ready carry a req_t (line address, request
// and completion cycles, kind, speculative and fetch marks).
// Response channel: rsp_valid/rsp_ready carry a rsp_t (prefetch valid and
// address, phase-ended flag, active offset after the request).
// Configuration: cfg_we with cfg_idx and cfg_data writes one register per
// cycle; write only while the block is idle.
// Sequence: an ignored request goes straight to the response register; a
// round-robin request probes one offset. A round-robin phase end by score
// adds the score clear; one by rounds adds the score search and decision
// plus the clear. A scan request probes the table once per offset, then
// searches the scores and decides, plus the clear on a phase end. The
// recent-request table has a single read port, and one score entry is
// touched per cycle.
// One request is in flight at a time; req_ready is high only when idle.
// A stalled response holds in its register until rsp_ready.
// Reset (rst, synchronous) restores register defaults, counters and the
// recent-table valid bits; the scores are then cleared with req_ready low.
module best_offset_prefetcher_top import bop_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic busy, out_pend;

  assign req_ready = !busy;

  bop_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(req_valid && req_ready),
    .out_fire(rsp_valid && rsp_ready),
    .sts(sts), .cmd(cmd), .busy(busy), .out_pend(out_pend)
  );

  bop_dp u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
    .req(req), .cmd(cmd), .sts(sts), .rsp(rsp)
  );

  assign rsp_valid = out_pend;
endmodule

>>> rtl/core/bop_ctrl.sv
`timescale 1ns / 1ps
module bop_ctrl import bop_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_fire,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic out_pend
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    busy = (state != S_IDLE);
    out_pend = (state == S_OUT);
    case (state)
      // clear the score store one entry per cycle after reset
      S_INIT: begin
        cmd.clr_step = 1'b1;
        cmd.probe_next = 1'b1;
        if (sts.probe_last) state_next = S_IDLE;
      end
      S_IDLE: if (in_fire) begin
        cmd.capture = 1'b1;
        state_next = S_RD;
      end
      S_RD: begin
        if (!sts.watched) begin
          state_next = S_OUT;
        end else if (sts.scan) begin
          cmd.probe_clr = 1'b1;
          state_next = S_SC_RD;
        end else begin
          cmd.rd_issue = 1'b1;
          state_next = S_RR_CHK;
        end
      end
      S_RR_CHK: begin
        cmd.rr_eval = 1'b1;
        if (sts.rr_hit_end) state_next = S_CLR;
        else if (sts.rr_round_end) begin
          cmd.best_clr = 1'b1;
          cmd.probe_clr = 1'b1;
          state_next = S_BEST;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_SC_RD: begin
        cmd.rd_issue = 1'b1;
        state_next = S_SC_CHK;
      end
      S_SC_CHK: begin
        cmd.sc_bump = 1'b1;
        cmd.probe_next = 1'b1;
        if (sts.probe_last) begin
          cmd.best_clr = 1'b1;
          state_next = S_BEST;
        end else state_next = S_SC_RD;
      end
      S_BEST: begin
        cmd.best_step = 1'b1;
        cmd.probe_next = 1'b1;
        if (sts.probe_last) state_next = S_BEST_WAIT;
      end
      // last score read is compared here
      S_BEST_WAIT: state_next = S_BEST_DONE;
      S_BEST_DONE: begin
        cmd.sc_decide = 1'b1;
        state_next = S_SC_DEC;
      end
      S_SC_DEC: begin
        cmd.probe_clr = 1'b1;
        if (sts.end_phase) state_next = S_CLR;
        else begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        cmd.probe_next = 1'b1;
        if (sts.probe_last) begin
          cmd.finish = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: if (out_fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule

>>> rtl/core/bop_dp.sv
`timescale 1ns / 1ps
module bop_dp import bop_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output rsp_t rsp
);
  localparam int PW = $clog2(OffsetCount);
  localparam logic [PW-1:0] PLast = PW'(OffsetCount - 1);

  logic watch_reads, watch_writes, scan_mode;
  logic [ScoreW-1:0] round_limit, score_limit;
  logic [OffW-1:0] active_offset;

  req_t r;
  logic watched, rd_hit_ok, end_phase;
  logic [PW-1:0] probe_index, probe, sc_idx_q;
  logic [ScoreW-1:0] round_count;
  logic [ScoreW-1:0] scores [OffsetCount];
  logic [ScoreW-1:0] sc_q, sc_wd;
  logic sc_we, best_cmp_q;
  logic [ScoreW-1:0] best_sc;
  logic [OffW-1:0] best_off, end_off;

  logic [RecentEntries-1:0] rvalid;
  logic [AddrW-1:0] rtag [RecentEntries];
  logic [AddrW-1:0] rdone [RecentEntries];
  logic [AddrW-1:0] rd_tag, rd_done, probe_addr, rd_addr_q;
  logic rd_valid;
  logic rr_hit_end, rr_round_end;

  assign probe_addr = r.line_addr - AddrW'(probe) - AddrW'(1);

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_tag <= rtag[probe_addr[SlotW-1:0]];
      rd_done <= rdone[probe_addr[SlotW-1:0]];
      rd_valid <= rvalid[probe_addr[SlotW-1:0]];
      rd_addr_q <= probe_addr;
    end
    if (cmd.finish && watched) begin
      rtag[r.line_addr[SlotW-1:0]] <= r.line_addr;
      rdone[r.line_addr[SlotW-1:0]] <= r.completion_cycle;
    end
  end
  assign rd_hit_ok = rd_valid && rd_tag == rd_addr_q && rd_done <= r.request_cycle;

  assign rr_hit_end = rd_hit_ok && score_limit != '0 && sc_q == score_limit - 8'd1;
  assign rr_round_end = !rr_hit_end && probe == PLast && round_count == round_limit;

  // score store: clear, or saturating bump of the entry read the cycle before
  always_comb begin
    sc_we = 1'b0;
    sc_wd = '0;
    if (cmd.clr_step) begin
      sc_we = 1'b1;
    end else if ((cmd.sc_bump || (cmd.rr_eval && !rr_hit_end)) && rd_hit_ok &&
                 sc_q != '1) begin
      sc_we = 1'b1;
      sc_wd = sc_q + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    sc_q <= scores[probe];
    sc_idx_q <= probe;
    if (sc_we) scores[probe] <= sc_wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_reads <= 1'b1;
      watch_writes <= 1'b1;
      round_limit <= 8'd100;
      score_limit <= 8'd31;
      active_offset <= 6'd1;
      scan_mode <= 1'b0;
      probe_index <= '0;
      probe <= '0;
      round_count <= '0;
      rvalid <= '0;
      end_phase <= 1'b0;
      best_cmp_q <= 1'b0;
    end else begin
      best_cmp_q <= cmd.best_step;
      if (cfg_we) begin
        case (cfg_idx)
          CfgWatchReads: watch_reads <= cfg_data[0];
          CfgWatchWrites: watch_writes <= cfg_data[0];
          CfgRoundLimit: round_limit <= cfg_data;
          CfgScoreLimit: score_limit <= cfg_data;
          CfgStartOffset: active_offset <= cfg_data[OffW-1:0];
          CfgScanMode: scan_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.capture) begin
        r <= req;
        watched <= !req.speculative && !req.instruction_fetch &&
                   ((watch_reads && req.req_kind == KindRead) ||
                    (watch_writes && req.req_kind == KindWrite));
        end_phase <= 1'b0;
        probe <= (probe_index > PLast) ? '0 : probe_index;
        rsp.prefetch_valid <= 1'b0;
        rsp.prefetch_addr <= '0;
        rsp.phase_ended <= 1'b0;
        rsp.new_offset <= active_offset;
      end
      if (cmd.rr_eval) begin
        if (rr_hit_end) begin
          end_phase <= 1'b1;
          end_off <= OffW'(probe) + 6'd1;
          probe <= '0;
        end else begin
          if (probe == PLast) begin
            if (!rr_round_end) begin
              probe_index <= '0;
              round_count <= round_count + 8'd1;
            end
          end else probe_index <= probe + PW'(1);
        end
      end
      if (cmd.probe_clr) probe <= '0;
      if (cmd.probe_next) probe <= (probe == PLast) ? '0 : probe + PW'(1);
      if (cmd.best_clr) begin
        best_sc <= 8'd1;
        best_off <= 6'd1;
      end
      if (best_cmp_q && sc_q >= best_sc) begin
        best_sc <= sc_q;
        best_off <= OffW'(sc_idx_q) + 6'd1;
      end
      if (cmd.sc_decide) begin
        if (!scan_mode) begin
          end_phase <= 1'b1;
          end_off <= best_off;
        end else if (best_sc == score_limit) begin
          end_phase <= 1'b1;
          end_off <= best_off;
        end else begin
          round_count <= round_count + 8'd1;
          if (round_count + 8'd1 == round_limit) begin
            end_phase <= 1'b1;
            end_off <= best_off;
          end
        end
      end
      if (cmd.finish && watched) begin
        rvalid[r.line_addr[SlotW-1:0]] <= 1'b1;
        rsp.prefetch_valid <= 1'b1;
        rsp.prefetch_addr <= r.line_addr + AddrW'(active_offset);
        rsp.phase_ended <= end_phase;
        if (end_phase) begin
          active_offset <= end_off;
          rsp.new_offset <= end_off;
          round_count <= '0;
          probe_index <= '0;
        end
      end
    end
  end

  assign sts.watched = watched;
  assign sts.scan = scan_mode;
  assign sts.probe_last = (probe == PLast);
  assign sts.rr_hit_end = rr_hit_end;
  assign sts.rr_round_end = rr_round_end;
  assign sts.end_phase = end_phase;
endmodule

>>> rtl/core/bop_checker.sv
`timescale 1ns / 1ps
module bop_checker import bop_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !req_ready) else $error("request taken while response pending");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped");
  a_no_pf_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.prefetch_valid |-> rsp.prefetch_addr == '0 && !rsp.phase_ended)
    else $error("ignored request shows prefetch");
  a_rsp_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !rsp_valid) else $error("response too early");
endmodule

bind best_offset_prefetcher_top bop_checker u_bop_checker (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
);

>>> dv/bop_checker.sv
`timescale 1ns / 1ps
module bop_scoreboard import bop_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_ready,
  input  rsp_t rsp,
  input  logic cfg_we,
  input  logic [CfgIdxW-1:0] cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  output int   fail_count,
  output int   pending_count
);

  // shadow configuration
  logic       watch_rd, watch_wr, scan_on;
  logic [7:0] round_lim, score_lim;
  logic [5:0] start_off;

  // shadow learning state
  logic [7:0]       scores [OffsetCount];
  logic [5:0]       probe;
  logic [7:0]       rounds;
  logic [5:0]       cur_off;
  logic             tbl_valid [RecentEntries];
  logic [AddrW-1:0] tbl_tag [RecentEntries];
  logic [AddrW-1:0] tbl_done [RecentEntries];

  // expected responses, oldest at rd_ptr
  rsp_t       exp_buf [16];
  logic [3:0] wr_ptr, rd_ptr;
  int         exp_count;

  assign pending_count = exp_count;

  function automatic logic recent_hit(logic [AddrW-1:0] a, logic [AddrW-1:0] cyc);
    int s;
    s = int'(a[SlotW-1:0]);
    return tbl_valid[s] && tbl_tag[s] == a && tbl_done[s] <= cyc;
  endfunction

  function automatic void raise_score(int i);
    if (scores[i] != 8'hFF) scores[i] = scores[i] + 8'd1;
  endfunction

  // best offset: ties go to the later offset, 1 when nothing scores
  function automatic int pick_best(output int best_sc);
    int off;
    off = 1;
    best_sc = 1;
    for (int i = 0; i < OffsetCount; i++)
      if (scores[i] >= best_sc) begin
        off = i + 1;
        best_sc = scores[i];
      end
    return off;
  endfunction

  function automatic void close_phase(int off);
    cur_off = off[5:0];
    for (int i = 0; i < OffsetCount; i++) scores[i] = '0;
    rounds = '0;
    probe = '0;
  endfunction

  function automatic logic train_one(logic [AddrW-1:0] a, logic [AddrW-1:0] cyc);
    int idx, sc;
    idx = probe;
    if (idx >= OffsetCount) idx = 0;
    if (recent_hit(a - AddrW'(idx + 1), cyc)) begin
      if (score_lim != 0 && scores[idx] == score_lim - 8'd1) begin
        close_phase(idx + 1);
        return 1'b1;
      end
      raise_score(idx);
    end
    if (idx == OffsetCount - 1) begin
      if (rounds == round_lim) begin
        close_phase(pick_best(sc));
        return 1'b1;
      end
      probe = '0;
      rounds = rounds + 8'd1;
    end else begin
      probe = 6'(idx + 1);
    end
    return 1'b0;
  endfunction

  function automatic logic train_all(logic [AddrW-1:0] a, logic [AddrW-1:0] cyc);
    int off, sc;
    for (int i = 0; i < OffsetCount; i++)
      if (recent_hit(a - AddrW'(i + 1), cyc)) raise_score(i);
    off = pick_best(sc);
    if (sc == score_lim) begin
      close_phase(off);
      return 1'b1;
    end
    rounds = rounds + 8'd1;
    if (rounds == round_lim) begin
      close_phase(off);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic rsp_t predict_prefetch(req_t r);
    rsp_t o;
    logic watched;
    int s;
    watched = (watch_rd && r.req_kind == KindRead) || (watch_wr && r.req_kind == KindWrite);
    o = '0;
    if (r.speculative || r.instruction_fetch || !watched) begin
      o.new_offset = cur_off;
      return o;
    end
    o.prefetch_valid = 1'b1;
    o.prefetch_addr = r.line_addr + AddrW'(cur_off);
    o.phase_ended = scan_on ? train_all(r.line_addr, r.request_cycle)
                            : train_one(r.line_addr, r.request_cycle);
    s = int'(r.line_addr[SlotW-1:0]);
    tbl_valid[s] = 1'b1;
    tbl_tag[s] = r.line_addr;
    tbl_done[s] = r.completion_cycle;
    o.new_offset = cur_off;
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      watch_rd = 1'b1;
      watch_wr = 1'b1;
      round_lim = 8'd100;
      score_lim = 8'd31;
      start_off = 6'd1;
      scan_on = 1'b0;
      for (int i = 0; i < OffsetCount; i++) scores[i] = '0;
      probe = '0;
      rounds = '0;
      cur_off = 6'd1;
      for (int i = 0; i < RecentEntries; i++) tbl_valid[i] = 1'b0;
      wr_ptr = '0;
      rd_ptr = '0;
      exp_count = 0;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CfgWatchReads:  watch_rd = cfg_data[0];
          CfgWatchWrites: watch_wr = cfg_data[0];
          CfgRoundLimit:  round_lim = cfg_data;
          CfgScoreLimit:  score_lim = cfg_data;
          CfgStartOffset: begin
            start_off = cfg_data[5:0];
            cur_off = start_off;
          end
          CfgScanMode:    scan_on = cfg_data[0];
          default: ;
        endcase
      end
      if (req_valid && req_ready) begin
        exp_buf[wr_ptr] = predict_prefetch(req);
        wr_ptr = wr_ptr + 4'd1;
        exp_count++;
      end
      if (rsp_valid && rsp_ready) begin
        if (exp_count == 0) begin
          $display("%0t: unexpected response %h", $time, rsp);
          fail_count++;
        end else begin
          want = exp_buf[rd_ptr];
          rd_ptr = rd_ptr + 4'd1;
          exp_count--;
          if (rsp.prefetch_valid !== want.prefetch_valid) begin
            $display("%0t: prefetch_valid exp %b got %b", $time,
                     want.prefetch_valid, rsp.prefetch_valid);
            fail_count++;
          end
          if (rsp.prefetch_addr !== want.prefetch_addr) begin
            $display("%0t: prefetch_addr exp %h got %h", $time,
                     want.prefetch_addr, rsp.prefetch_addr);
            fail_count++;
          end
          if (rsp.phase_ended !== want.phase_ended) begin
            $display("%0t: phase_ended exp %b got %b", $time,
                     want.phase_ended, rsp.phase_ended);
            fail_count++;
          end
          if (rsp.new_offset !== want.new_offset) begin
            $display("%0t: new_offset exp %0d got %0d", $time,
                     want.new_offset, rsp.new_offset);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

>>> dv/best_offset_prefetcher_top_tb.sv
`timescale 1ns / 1ps
module best_offset_prefetcher_top_tb;
  import bop_pkg::*;

  // an index that names no register
  localparam logic [CfgIdxW-1:0] CfgNoReg = 3'd7;

  logic clk;
  logic rst;
  logic req_valid, req_ready;
  req_t req;
  logic rsp_valid, rsp_ready;
  rsp_t rsp;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int fail_count, pending_count;

  // sender and receiver idle in bursts only while this is set
  logic allow_idle;
  logic [AddrW-1:0] stream_base;
  logic [AddrW-1:0] now_cycle;

  best_offset_prefetcher_top dut (.*);

  bop_scoreboard u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous ceiling: scan requests run long, plus stalls
  initial begin
    #60ms;
    $display("== FAIL ==");
    $finish;
  end

  // Receiver: drop ready for random bursts while idling is allowed.
  initial begin
    int hold;
    rsp_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (allow_idle && $urandom_range(0, 3) == 0) begin
        hold = $urandom_range(1, 14);
        rsp_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Hold the request until accepted, then drop valid unless another follows.
  task automatic send_request(req_t r);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic wait_drained;
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [AddrW-1:0] rand_wide();
    return AddrW'({$urandom(), $urandom()});
  endfunction

  // Mostly a strided miss stream with an advancing clock, so table hits
  // happen and phases end; the rest is noise across every field.
  function automatic req_t make_miss();
    req_t r;
    int pick;
    pick = $urandom_range(0, 9);
    r.line_addr = stream_base;
    r.request_cycle = now_cycle;
    r.completion_cycle = now_cycle + $urandom_range(0, 40);
    r.req_kind = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(2, 3))
                                             : 2'($urandom_range(0, 1));
    r.speculative = ($urandom_range(0, 15) == 0);
    r.instruction_fetch = ($urandom_range(0, 15) == 0);
    if (pick == 0) begin
      r.line_addr = rand_wide();
      r.request_cycle = rand_wide();
      r.completion_cycle = rand_wide();
    end else if (pick == 1) begin
      r.completion_cycle = now_cycle + 1000;
    end
    return r;
  endfunction

  task automatic run_random(int count);
    int stride;
    stride = $urandom_range(1, 63);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 60) == 0) stride = $urandom_range(1, 63);
      send_request(make_miss());
      stream_base = stream_base + AddrW'(stride);
      now_cycle = now_cycle + $urandom_range(10, 60);
    end
  endtask

  initial begin
    req_t d;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    allow_idle = 1'b1;
    stream_base = 48'h1000;
    now_cycle = 48'd100;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, every kind, ignored marks, wrap of the address.
    d = '0;
    d.line_addr = '1;
    d.completion_cycle = '1;
    send_request(d);
    d.req_kind = KindWrite;
    d.request_cycle = '1;
    send_request(d);
    d.req_kind = KindOther;
    send_request(d);
    d.req_kind = KindReserved;
    send_request(d);
    d = '0;
    d.speculative = 1'b1;
    send_request(d);
    d = '0;
    d.instruction_fetch = 1'b1;
    send_request(d);
    // a miss one line above its predecessor, requested at exactly its completion cycle, wrapping at zero
    d = '0;
    d.line_addr = '1;
    d.completion_cycle = 48'd5;
    send_request(d);
    d.line_addr = '0;
    d.request_cycle = 48'd5;
    send_request(d);
    wait_drained();

    // Reads and writes unwatched, start offset 0, quick phases.
    write_reg(CfgWatchReads, 8'd0);
    write_reg(CfgWatchWrites, 8'd0);
    write_reg(CfgStartOffset, 8'd0);
    run_random(10);
    wait_drained();
    write_reg(CfgWatchReads, 8'd1);
    write_reg(CfgRoundLimit, 8'd0);
    write_reg(CfgScoreLimit, 8'd1);
    run_random(200);
    wait_drained();
    write_reg(CfgWatchWrites, 8'd1);
    write_reg(CfgScoreLimit, 8'd0);
    write_reg(CfgStartOffset, 8'd63);
    write_reg(CfgNoReg, 8'hFF);
    run_random(300);
    wait_drained();

    // Scan mode phases.
    write_reg(CfgScanMode, 8'd1);
    write_reg(CfgRoundLimit, 8'd0);
    write_reg(CfgScoreLimit, 8'd255);
    run_random(300);
    wait_drained();
    write_reg(CfgRoundLimit, 8'd255);
    write_reg(CfgScoreLimit, 8'd3);
    write_reg(CfgStartOffset, 8'd17);
    run_random(300);
    wait_drained();
    write_reg(CfgRoundLimit, 8'd20);
    write_reg(CfgScoreLimit, 8'd8);
    run_random(200);
    wait_drained();

    // Back to round-robin; last stretch runs at full rate.
    write_reg(CfgScanMode, 8'd0);
    write_reg(CfgRoundLimit, 8'd2);
    write_reg(CfgScoreLimit, 8'd2);
    run_random(300);
    allow_idle = 1'b0;
    run_random(200);
    wait_drained();
    repeat (300) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
